// ===== src/salt_pkg.sv =====
// shared types and constants for the sampled allocation leak tracker
`timescale 1ns / 1ps
package salt_pkg;

    localparam logic [63:0] FIB_MULT = 64'd11400714819323198485;

    localparam logic [2:0] ST_SKIPPED   = 3'd0;
    localparam logic [2:0] ST_RECORDED  = 3'd1;
    localparam logic [2:0] ST_SITE_FULL = 3'd2;
    localparam logic [2:0] ST_NO_SLOT   = 3'd3;
    localparam logic [2:0] ST_FREE_HIT  = 3'd4;
    localparam logic [2:0] ST_FREE_MISS = 3'd5;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH0,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_SITE_RD,
        S_SITE_CMP,
        S_SITE_UPD,
        S_SITE_WR,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_FREE_RD,
        S_FREE_CMP,
        S_FREE_UPD,
        S_FREE_WR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [30:0] request_number;
        logic [31:0] block_size;
        logic [31:0] stack_hash;
        logic [3:0]  frame_count;
    } event_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         site_index;
        logic signed [47:0] site_live_total;
        logic signed [31:0] site_live_blocks;
        logic [8:0]         sites_in_use;
        logic signed [47:0] all_live_bytes;
    } result_t;

endpackage

// ===== src/salt_if.sv =====
// valid/ready channel interfaces for events, results and configuration
`timescale 1ns / 1ps
interface salt_event_if;
    logic              valid;
    logic              ready;
    salt_pkg::event_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface salt_result_if;
    logic              valid;
    logic              ready;
    salt_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface salt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/sampled_allocation_leak_tracker.sv =====
// top level of the sampled allocation leak tracker
`timescale 1ns / 1ps
// Sampled allocation leak tracker. Events enter on evt, one item at a time,
// and each gives exactly one result item on res. Every sample_period-th
// allocation is sampled: its call site (stack hash plus frame count, capped at
// MAX_FRAMES) is found or added in the site memory by a linear scan, one entry
// at a time, and a record keyed by request number goes into an open-addressed
// slot memory (Fibonacci home slot, up to PROBE_LIMIT linear probes). A free
// walks the same chain and retires the record. The time per item grows with
// the sites scanned and the probes taken, plus any wait on res.ready; the site
// scan and the single-port slot memory set this. The Fibonacci hash uses one
// 32x32 multiplier twice. After reset a clearing pass empties the slot memory
// before the first item is accepted; configuration writes are taken at any
// time and apply from the next accepted item.
module sampled_allocation_leak_tracker #(
    parameter int SITE_SLOTS      = 256,
    parameter int SLOT_INDEX_BITS = 10,
    parameter int PROBE_LIMIT     = 64,
    parameter int MAX_FRAMES      = 12
) (
    input  logic clk,
    input  logic rst_n,
    salt_event_if.sink    evt,
    salt_result_if.source res,
    salt_cfg_if.sink      cfg
);
    localparam int SB = $clog2(SITE_SLOTS);
    localparam int FB = $clog2(SITE_SLOTS + 1);
    localparam int SLOTS = 1 << SLOT_INDEX_BITS;
    localparam int PB = $clog2(PROBE_LIMIT + 1);

    // site memory
    logic [31:0] site_hash_mem [SITE_SLOTS];
    logic [3:0]  site_depth_mem [SITE_SLOTS];
    logic [47:0] site_live_mem [SITE_SLOTS];
    logic [47:0] site_cum_mem [SITE_SLOTS];
    logic [31:0] site_blk_mem [SITE_SLOTS];
    // slot memory
    logic [30:0] slot_req_mem [SLOTS];
    logic [SB-1:0] slot_site_mem [SLOTS];
    logic [31:0] slot_size_mem [SLOTS];

    salt_pkg::state_t state_reg, state_next;
    logic [15:0] period_reg;
    logic [15:0] count_reg, count_next;
    logic [FB-1:0] fill_reg, fill_next;
    logic [47:0] sum_reg, sum_next;
    salt_pkg::event_t ev_reg;
    salt_pkg::event_t ev_in;
    logic [3:0] depth_sat;

    // hash partial products: low 64 bits of req * mult
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p_reg;
    logic [63:0] acc_reg, acc_next;

    logic [FB-1:0] scan_reg, scan_next;
    logic [SLOT_INDEX_BITS-1:0] slot_reg, slot_next;
    logic [PB-1:0] probe_reg, probe_next;
    logic [SLOT_INDEX_BITS:0] clr_reg;

    // registered read data
    logic [31:0] rd_hash;
    logic [3:0]  rd_depth;
    logic [47:0] rd_live, rd_cum;
    logic [31:0] rd_blk;
    logic [30:0] rd_req;
    logic [SB-1:0] rd_ssite;
    logic [31:0] rd_ssize;

    logic [SB-1:0] site_reg, site_next;
    logic site_ok_reg, site_ok_next;
    // site was just added, its memory entry is not valid yet
    logic fresh_reg, fresh_next;
    logic [47:0] nlive_reg, nlive_next, ncum_reg, ncum_next;
    logic [31:0] nblk_reg, nblk_next;
    logic [2:0] status_reg, status_next;
    logic out_valid_reg;
    salt_pkg::result_t res_reg, res_next;

    logic sampled;
    logic [16:0] cnt_inc;

    assign depth_sat = (evt.data.frame_count > 4'(MAX_FRAMES)) ? 4'(MAX_FRAMES)
                                                               : evt.data.frame_count;
    assign cnt_inc = {1'b0, count_reg} + 17'd1;
    assign sampled = cnt_inc >= {1'b0, period_reg};

    assign cfg.ready = 1'b1;
    assign evt.ready = (state_reg == salt_pkg::S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = res_reg;

    // incoming item with the frame count capped
    always_comb
    begin
        ev_in = evt.data;
        ev_in.frame_count = depth_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
        end
        else if (cfg.valid)
        begin
            period_reg <= cfg.data;
        end
    end

    // multiplier operand select: 64-bit constant split into two 32-bit halves,
    // the 31-bit request fits one operand
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            salt_pkg::S_HASH0:
            begin
                mul_a = {1'b0, ev_reg.request_number};
                mul_b = salt_pkg::FIB_MULT[31:0];
            end
            salt_pkg::S_HASH1:
            begin
                mul_a = {1'b0, ev_reg.request_number};
                mul_b = salt_pkg::FIB_MULT[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // memories
    always_ff @(posedge clk)
    begin
        rd_hash  <= site_hash_mem[scan_reg[SB-1:0]];
        rd_depth <= site_depth_mem[scan_reg[SB-1:0]];
        rd_live  <= site_live_mem[site_next];
        rd_cum   <= site_cum_mem[site_next];
        rd_blk   <= site_blk_mem[site_next];
        if (state_reg == salt_pkg::S_SITE_WR
            || (state_reg == salt_pkg::S_FREE_WR && site_ok_reg))
        begin
            site_live_mem[site_reg] <= nlive_reg;
            site_cum_mem[site_reg]  <= ncum_reg;
            site_blk_mem[site_reg]  <= nblk_reg;
            if (state_reg == salt_pkg::S_SITE_WR)
            begin
                site_hash_mem[site_reg]  <= ev_reg.stack_hash;
                site_depth_mem[site_reg] <= ev_reg.frame_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_req   <= slot_req_mem[slot_reg];
        rd_ssite <= slot_site_mem[slot_reg];
        rd_ssize <= slot_size_mem[slot_reg];
        if (state_reg == salt_pkg::S_CLEAR)
        begin
            slot_req_mem[clr_reg[SLOT_INDEX_BITS-1:0]] <= '0;
        end
        else if (state_reg == salt_pkg::S_PROBE_CMP && rd_req == '0)
        begin
            slot_req_mem[slot_reg]  <= ev_reg.request_number;
            slot_site_mem[slot_reg] <= site_reg;
            slot_size_mem[slot_reg] <= ev_reg.block_size;
        end
        else if (state_reg == salt_pkg::S_FREE_CMP && rd_req == ev_reg.request_number)
        begin
            slot_req_mem[slot_reg] <= '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salt_pkg::S_CLEAR:
                if (clr_reg == (SLOT_INDEX_BITS+1)'(SLOTS - 1))
                    state_next = salt_pkg::S_IDLE;
            salt_pkg::S_IDLE:
                if (evt.valid)
                begin
                    if (period_reg == '0)
                        state_next = salt_pkg::S_OUT;
                    else if (evt.data.req_type == salt_pkg::REQ_ALLOC)
                        state_next = sampled ? salt_pkg::S_SITE_RD : salt_pkg::S_OUT;
                    else
                        state_next = (evt.data.request_number != '0) ? salt_pkg::S_HASH0
                                                                     : salt_pkg::S_OUT;
                end
            salt_pkg::S_HASH0: state_next = salt_pkg::S_HASH1;
            salt_pkg::S_HASH1: state_next = salt_pkg::S_HASH2;
            salt_pkg::S_HASH2: state_next = salt_pkg::S_HASH3;
            salt_pkg::S_HASH3:
                state_next = (ev_reg.req_type == salt_pkg::REQ_FREE) ? salt_pkg::S_FREE_RD
                                                                     : salt_pkg::S_PROBE_RD;
            salt_pkg::S_SITE_RD:
                if (scan_reg >= fill_reg)
                    state_next = (fill_reg >= FB'(SITE_SLOTS)) ? salt_pkg::S_OUT
                                                               : salt_pkg::S_SITE_UPD;
                else
                    state_next = salt_pkg::S_SITE_CMP;
            salt_pkg::S_SITE_CMP:
                if (rd_hash == ev_reg.stack_hash && rd_depth == ev_reg.frame_count)
                    state_next = salt_pkg::S_SITE_UPD;
                else
                    state_next = salt_pkg::S_SITE_RD;
            salt_pkg::S_SITE_UPD: state_next = salt_pkg::S_SITE_WR;
            salt_pkg::S_SITE_WR:
                state_next = (ev_reg.request_number != '0) ? salt_pkg::S_HASH0
                                                           : salt_pkg::S_OUT;
            salt_pkg::S_PROBE_RD: state_next = salt_pkg::S_PROBE_CMP;
            salt_pkg::S_PROBE_CMP:
                if (rd_req == '0 || probe_reg == PB'(PROBE_LIMIT - 1))
                    state_next = salt_pkg::S_OUT;
                else
                    state_next = salt_pkg::S_PROBE_RD;
            salt_pkg::S_FREE_RD: state_next = salt_pkg::S_FREE_CMP;
            salt_pkg::S_FREE_CMP:
                if (rd_req == ev_reg.request_number)
                    state_next = salt_pkg::S_FREE_UPD;
                else if (rd_req == '0 || probe_reg == PB'(PROBE_LIMIT - 1))
                    state_next = salt_pkg::S_OUT;
                else
                    state_next = salt_pkg::S_FREE_RD;
            salt_pkg::S_FREE_UPD: state_next = salt_pkg::S_FREE_WR;
            salt_pkg::S_FREE_WR: state_next = salt_pkg::S_OUT;
            salt_pkg::S_OUT:
                if (!out_valid_reg || res.ready)
                    state_next = salt_pkg::S_IDLE;
            default: state_next = salt_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next = count_reg;
        fill_next = fill_reg;
        sum_next = sum_reg;
        acc_next = acc_reg;
        scan_next = scan_reg;
        slot_next = slot_reg;
        probe_next = probe_reg;
        site_next = site_reg;
        site_ok_next = site_ok_reg;
        fresh_next = fresh_reg;
        nlive_next = nlive_reg;
        ncum_next = ncum_reg;
        nblk_next = nblk_reg;
        status_next = status_reg;
        res_next = res_reg;
        case (state_reg)
            salt_pkg::S_IDLE:
            begin
                scan_next = '0;
                probe_next = '0;
                site_ok_next = 1'b0;
                fresh_next = 1'b0;
                site_next = '0;
                status_next = salt_pkg::ST_SKIPPED;
                if (evt.valid && period_reg != '0 && evt.data.req_type == salt_pkg::REQ_ALLOC)
                    count_next = sampled ? '0 : cnt_inc[15:0];
                if (evt.valid && period_reg != '0 && evt.data.req_type == salt_pkg::REQ_FREE
                    && evt.data.request_number != '0)
                    status_next = salt_pkg::ST_FREE_MISS;
                if (evt.valid && period_reg != '0 && evt.data.req_type == salt_pkg::REQ_ALLOC
                    && sampled)
                    status_next = salt_pkg::ST_SITE_FULL;
            end
            salt_pkg::S_HASH1: acc_next = mul_p_reg;
            // high partial product only reaches the upper word
            salt_pkg::S_HASH2:
                acc_next = {acc_reg[63:32] + mul_p_reg[31:0], acc_reg[31:0]};
            salt_pkg::S_HASH3:
            begin
                slot_next = acc_reg[63 -: SLOT_INDEX_BITS];
                probe_next = '0;
            end
            salt_pkg::S_SITE_RD:
                if (scan_reg >= fill_reg && fill_reg < FB'(SITE_SLOTS))
                begin
                    site_next = scan_reg[SB-1:0];
                    fill_next = fill_reg + 1'b1;
                    fresh_next = 1'b1;
                end
            salt_pkg::S_SITE_CMP:
                if (rd_hash == ev_reg.stack_hash && rd_depth == ev_reg.frame_count)
                    site_next = scan_reg[SB-1:0];
                else
                    scan_next = scan_reg + 1'b1;
            salt_pkg::S_SITE_UPD:
            begin
                site_ok_next = 1'b1;
                if (fresh_reg)
                begin
                    nlive_next = {16'd0, ev_reg.block_size};
                    ncum_next = {16'd0, ev_reg.block_size};
                    nblk_next = 32'd1;
                end
                else
                begin
                    nlive_next = rd_live + {16'd0, ev_reg.block_size};
                    ncum_next = rd_cum + {16'd0, ev_reg.block_size};
                    nblk_next = rd_blk + 32'd1;
                end
                sum_next = sum_reg + {16'd0, ev_reg.block_size};
                status_next = salt_pkg::ST_NO_SLOT;
            end
            salt_pkg::S_PROBE_CMP:
                if (rd_req == '0)
                    status_next = salt_pkg::ST_RECORDED;
                else
                begin
                    slot_next = slot_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            salt_pkg::S_FREE_CMP:
                if (rd_req == ev_reg.request_number)
                begin
                    site_next = rd_ssite;
                    site_ok_next = {1'b0, rd_ssite} < fill_reg;
                    nlive_next = {16'd0, rd_ssize};
                    status_next = salt_pkg::ST_FREE_HIT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            salt_pkg::S_FREE_UPD:
                if (site_ok_reg)
                begin
                    sum_next = sum_reg - nlive_reg;
                    nlive_next = rd_live - nlive_reg;
                    ncum_next = rd_cum;
                    nblk_next = rd_blk - 32'd1;
                end
            salt_pkg::S_OUT:
            begin
                res_next.status = status_reg;
                res_next.site_index = site_ok_reg ? 8'(site_reg) : 8'd0;
                res_next.site_live_total = site_ok_reg ? nlive_reg : '0;
                res_next.site_live_blocks = site_ok_reg ? nblk_reg : '0;
                res_next.sites_in_use = 9'(fill_reg);
                res_next.all_live_bytes = sum_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        nlive_reg <= nlive_next;
        ncum_reg <= ncum_next;
        nblk_reg <= nblk_next;
        if (evt.valid && evt.ready)
        begin
            ev_reg <= ev_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salt_pkg::S_CLEAR;
            clr_reg <= '0;
            count_reg <= '0;
            fill_reg <= '0;
            sum_reg <= '0;
            scan_reg <= '0;
            slot_reg <= '0;
            probe_reg <= '0;
            site_reg <= '0;
            site_ok_reg <= 1'b0;
            fresh_reg <= 1'b0;
            status_reg <= '0;
            out_valid_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_reg + 1'b1;
            count_reg <= count_next;
            fill_reg <= fill_next;
            sum_reg <= sum_next;
            scan_reg <= scan_next;
            slot_reg <= slot_next;
            probe_reg <= probe_next;
            site_reg <= site_next;
            site_ok_reg <= site_ok_next;
            fresh_reg <= fresh_next;
            status_reg <= status_next;
            if (state_reg == salt_pkg::S_OUT && (!out_valid_reg || res.ready))
            begin
                out_valid_reg <= 1'b1;
                res_reg <= res_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // checks
    fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FB'(SITE_SLOTS))
        else $error("site fill above capacity");

    fill_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg >= $past(fill_reg))
        else $error("site fill went down");

    no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != salt_pkg::S_IDLE) |-> !evt.ready)
        else $error("ready while busy");

    status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.data.status <= salt_pkg::ST_FREE_MISS))
        else $error("bad status code");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the sampled allocation leak tracker
`timescale 1ns / 1ps
module tb_top;

    localparam int SITES     = 256;
    localparam int SLOT_BITS = 10;
    localparam int SLOTS     = 1 << SLOT_BITS;
    localparam int PROBES    = 64;
    localparam int FRAMES    = 12;
    localparam int SETTLE    = 2 * SITES + 2 * PROBES + 40;
    localparam longint CYCLE_LIMIT = 10000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    salt_event_if  evt ();
    salt_result_if res ();
    salt_cfg_if    cfg ();

    sampled_allocation_leak_tracker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    // predictor state
    logic [15:0] period;
    logic [15:0] alloc_count;
    logic [31:0] site_hash [SITES];
    logic [3:0]  site_depth [SITES];
    logic [47:0] site_live [SITES];
    logic [31:0] site_blocks [SITES];
    int          site_fill;
    logic [30:0] slot_req [SLOTS];
    logic [7:0]  slot_site [SLOTS];
    logic [31:0] slot_size [SLOTS];
    logic [47:0] live_sum;

    salt_pkg::event_t  pending_events [$];
    salt_pkg::result_t expected_results [$];
    logic [30:0] live_requests [$];

    int  errors = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    longint cycles = 0;

    function automatic logic [SLOT_BITS-1:0] home_slot(logic [30:0] req);
        logic [63:0] prod;
        prod = {33'd0, req} * salt_pkg::FIB_MULT;
        return prod[63 -: SLOT_BITS];
    endfunction

    function automatic salt_pkg::result_t track_event(salt_pkg::event_t e);
        salt_pkg::result_t r;
        logic [3:0] dep;
        int site;
        int s;
        site = -1;
        r = '0;
        r.status = salt_pkg::ST_SKIPPED;
        dep = (e.frame_count > FRAMES) ? 4'(FRAMES) : e.frame_count;
        if (period != 0 && e.req_type == salt_pkg::REQ_ALLOC)
        begin
            if (32'(alloc_count) + 1 >= 32'(period))
            begin
                alloc_count = '0;
                for (int i = 0; i < site_fill; i++)
                begin
                    if (site < 0 && site_hash[i] == e.stack_hash && site_depth[i] == dep)
                        site = i;
                end
                if (site < 0 && site_fill < SITES)
                begin
                    site = site_fill;
                    site_fill++;
                    site_hash[site] = e.stack_hash;
                    site_depth[site] = dep;
                    site_live[site] = '0;
                    site_blocks[site] = '0;
                end
                if (site < 0)
                    r.status = salt_pkg::ST_SITE_FULL;
                else
                begin
                    site_live[site] += 48'(e.block_size);
                    site_blocks[site] += 1;
                    live_sum += 48'(e.block_size);
                    r.status = salt_pkg::ST_NO_SLOT;
                    if (e.request_number != 0)
                    begin
                        for (int t = 0; t < PROBES; t++)
                        begin
                            s = (int'(home_slot(e.request_number)) + t) % SLOTS;
                            if (slot_req[s] == 0)
                            begin
                                slot_req[s] = e.request_number;
                                slot_site[s] = 8'(site);
                                slot_size[s] = e.block_size;
                                r.status = salt_pkg::ST_RECORDED;
                                break;
                            end
                        end
                    end
                end
            end
            else
                alloc_count = alloc_count + 1;
        end
        else if (period != 0 && e.req_type == salt_pkg::REQ_FREE && e.request_number != 0)
        begin
            r.status = salt_pkg::ST_FREE_MISS;
            for (int t = 0; t < PROBES; t++)
            begin
                s = (int'(home_slot(e.request_number)) + t) % SLOTS;
                if (slot_req[s] == e.request_number)
                begin
                    if (int'(slot_site[s]) < site_fill)
                    begin
                        site_live[slot_site[s]] -= 48'(slot_size[s]);
                        site_blocks[slot_site[s]] -= 1;
                        live_sum -= 48'(slot_size[s]);
                        site = slot_site[s];
                    end
                    slot_req[s] = '0;
                    r.status = salt_pkg::ST_FREE_HIT;
                    break;
                end
                if (slot_req[s] == 0)
                    break;
            end
        end
        if (site >= 0)
        begin
            r.site_index = 8'(site);
            r.site_live_total = site_live[site];
            r.site_live_blocks = site_blocks[site];
        end
        r.sites_in_use = 9'(site_fill);
        r.all_live_bytes = live_sum;
        return r;
    endfunction

    // driver: takes items from the pending queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt.valid <= 1'b0;
            evt.data <= '0;
        end
        else if (!evt.valid || evt.ready)
        begin
            if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                evt.valid <= 1'b1;
                evt.data <= pending_events.pop_front();
            end
            else
                evt.valid <= 1'b0;
        end
    end

    // prediction on acceptance, so the model sees events in block order
    always @(posedge clk)
    begin
        if (rst_n && evt.valid && evt.ready)
            expected_results.push_back(track_event(evt.data));
    end

    // monitor: random back-pressure and compare
    always @(posedge clk or negedge rst_n)
    begin
        salt_pkg::result_t want;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            res.ready <= ($urandom_range(99) >= stall_pct);
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result item %p", res.data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.data !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", want, res.data);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_period(logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        period = value;
        cfg.valid <= 1'b0;
    endtask

    // wait until queued items are consumed and all results are back
    task automatic drain();
        do @(negedge clk);
        while (pending_events.size() > 0 || evt.valid || expected_results.size() > 0
               || res.valid);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic salt_pkg::event_t make_event(bit kind, logic [30:0] req,
                                                    logic [31:0] size, logic [31:0] hash,
                                                    logic [3:0] depth);
        salt_pkg::event_t e;
        e.req_type = kind;
        e.request_number = req;
        e.block_size = size;
        e.stack_hash = hash;
        e.frame_count = depth;
        return e;
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            default: return $urandom_range(4096);
        endcase
    endfunction

    // mostly real alloc/free pairs over a modest pool of sites
    task automatic queue_random(int count, int site_pool);
        salt_pkg::event_t e;
        logic [30:0] req;
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            if (k < 55)
            begin
                req = 31'($urandom());
                if ($urandom_range(9) == 0)
                    req = 31'($urandom_range(7));
                if ($urandom_range(30) == 0)
                    req = 31'h7FFF_FFFF;
                live_requests.push_back(req);
                e = make_event(salt_pkg::REQ_ALLOC, req, rand_size(),
                               32'($urandom_range(site_pool)) ^ 32'hA5A5_0000,
                               4'($urandom_range(15)));
                if ($urandom_range(15) == 0)
                    e.stack_hash = $urandom();
            end
            else if (k < 90 && live_requests.size() > 0)
            begin
                k = $urandom_range(live_requests.size() - 1);
                e = make_event(salt_pkg::REQ_FREE, live_requests[k], $urandom(), $urandom(),
                               4'($urandom_range(15)));
                live_requests.delete(k);
            end
            else
                e = make_event(1'($urandom()), 31'($urandom()), $urandom(), $urandom(),
                               4'($urandom_range(15)));
            pending_events.push_back(e);
        end
    endtask

    initial
    begin
        period = '0;
        alloc_count = '0;
        site_fill = 0;
        live_sum = '0;
        for (int i = 0; i < SLOTS; i++)
            slot_req[i] = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // disabled block: everything is skipped
        pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'd5, 32'd100, 32'h1, 4'd3));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd5, 32'd0, 32'h1, 4'd3));
        drain();

        // period 1: every allocation sampled
        write_period(16'd1);
        pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'd1, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 4'd15));
        pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'd1, 32'd0,
                                            32'hFFFF_FFFF, 4'd12));
        pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'd0, 32'd7, 32'h0, 4'd0));
        pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'h7FFF_FFFF, 32'd9,
                                            32'h0, 4'd1));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd1, 32'd0, 32'h0, 4'd0));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd1, 32'd0, 32'h0, 4'd0));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd1, 32'd0, 32'h0, 4'd0));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd0, 32'd0, 32'h0, 4'd0));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd12345, 32'd0, 32'h0, 4'd0));
        // same home slot many times: fill a probe chain past the limit
        for (int i = 0; i < PROBES + 2; i++)
            pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'd77, 32'd1,
                                                32'h55, 4'd2));
        pending_events.push_back(make_event(salt_pkg::REQ_FREE, 31'd77, 32'd0, 32'h0, 4'd0));
        drain();

        // several periods with random traffic and idling phases
        write_period(16'd3);
        queue_random(290, 40);
        drain();
        idle_pct = 45;
        write_period(16'd2);
        queue_random(290, 60);
        drain();
        idle_pct = 0;
        stall_pct = 45;
        write_period(16'd1);
        // many distinct sites to overflow the site table
        for (int i = 0; i < SITES + 10; i++)
            pending_events.push_back(make_event(salt_pkg::REQ_ALLOC, 31'($urandom()), 32'd3,
                                                32'h1000_0000 + 32'(i), 4'd5));
        queue_random(150, 40);
        drain();
        idle_pct = 38;
        stall_pct = 38;
        write_period(16'hFFFF);
        queue_random(100, 40);
        drain();
        // lowered period below the running count samples at once
        write_period(16'd1);
        queue_random(250, 40);
        drain();
        write_period(16'd0);
        queue_random(30, 40);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
